// ----- design/apac_pkg.sv -----
`default_nettype none
package apac_pkg;

    localparam int DATA_WIDTH = 32;
    // trial divisor and remainder: d*d stays at most one step past the value
    localparam int DIV_W = DATA_WIDTH / 2 + 1;
    localparam int REM_W = DIV_W + 1;
    localparam int SQ_W = 2 * DIV_W;
    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam int STEP_W = 4;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_D,
        OP_SQUARE,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_NEXT_D,
        OP_SET_YES,
        OP_SET_NO,
        OP_EMIT
    } op_t;

    // jump is taken when the condition is true, else the step counter advances
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_NOT_CAND,
        C_IS_TWO,
        C_SQ_GT,
        C_DIV_BUSY,
        C_REM_ZERO,
        C_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    localparam step_t S_IDLE   = 4'd0;
    localparam step_t S_SCREEN = 4'd1;
    localparam step_t S_TWO    = 4'd2;
    localparam step_t S_SQUARE = 4'd3;
    localparam step_t S_BOUND  = 4'd4;
    localparam step_t S_DIV    = 4'd5;
    localparam step_t S_TEST   = 4'd6;
    localparam step_t S_LOOP   = 4'd7;
    localparam step_t S_YES    = 4'd8;
    localparam step_t S_NO     = 4'd9;
    localparam step_t S_EMIT   = 4'd10;

    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        case (step)
            S_IDLE:   w = '{OP_LOAD,      C_NO_INPUT,    S_IDLE};
            S_SCREEN: w = '{OP_NONE,      C_NOT_CAND,    S_NO};
            S_TWO:    w = '{OP_INIT_D,    C_IS_TWO,      S_YES};
            S_SQUARE: w = '{OP_SQUARE,    C_NEVER,       S_IDLE};
            S_BOUND:  w = '{OP_DIV_START, C_SQ_GT,       S_YES};
            S_DIV:    w = '{OP_DIV_STEP,  C_DIV_BUSY,    S_DIV};
            S_TEST:   w = '{OP_NEXT_D,    C_REM_ZERO,    S_NO};
            S_LOOP:   w = '{OP_NONE,      C_ALWAYS,      S_SQUARE};
            S_YES:    w = '{OP_SET_YES,   C_ALWAYS,      S_EMIT};
            S_NO:     w = '{OP_SET_NO,    C_NEVER,       S_IDLE};
            S_EMIT:   w = '{OP_EMIT,      C_OUT_BLOCKED, S_EMIT};
            default:  w = '{OP_NONE,      C_ALWAYS,      S_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- design/all_prime_array_check_unit.sv -----
`default_nettype none
// Tests each incoming element for primality by trial division over odd divisors
// and reports, with each result, whether every element of the current array has
// been prime so far; array_done echoes last_element and marks the array verdict.
// One element is in work at a time. A value ruled out by sign, size or parity
// goes from the screen step to the no and emit steps; the value two goes through
// the two, yes and emit steps. Otherwise each odd divisor d from 3 while d*d <= value
// costs a pass through the restoring remainder unit at one bit a cycle, plus
// square, bound, test and loop steps, so a large prime near 2^31 is tried
// against about 23170 divisors. A finished result waits in the output register
// while the next element is taken.
module all_prime_array_check_unit
    import apac_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [DATA_WIDTH-1:0] value,
    input  wire logic                         last_element,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              element_is_prime,
    output logic                              all_prime_so_far,
    output logic                              array_done
);

    uword_t uw;

    step_t step_reg, step_next;
    logic [DATA_WIDTH-1:0] v_reg, v_next;
    logic last_reg, last_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [SQ_W-1:0] sq_reg, sq_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic prime_reg, prime_next;
    logic run_reg, run_next;
    logic out_valid_reg, out_valid_next;
    logic out_prime_reg, out_prime_next;
    logic out_all_reg, out_all_next;
    logic out_done_reg, out_done_next;

    logic cond_true;
    logic v_le_one;
    logic v_is_two;
    logic out_blocked;
    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] d_ext;
    logic all_now;

    assign uw = ucode_rom(step_reg);

    assign v_le_one = (v_reg[DATA_WIDTH-1:1] == '0);
    assign v_is_two = (v_reg == DATA_WIDTH'(2));
    assign out_blocked = out_valid_reg && out_stall;
    assign rem_shift = {rem_reg[REM_W-2:0], v_reg[cnt_reg]};
    assign d_ext = {1'b0, d_reg};
    assign all_now = run_reg & prime_reg;

    always_comb
    begin
        case (uw.cond)
            C_NEVER:       cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_NO_INPUT:    cond_true = !in_valid;
            C_NOT_CAND:    cond_true = v_reg[DATA_WIDTH-1] || v_le_one
                                       || (!v_reg[0] && !v_is_two);
            C_IS_TWO:      cond_true = v_is_two;
            C_SQ_GT:       cond_true = (sq_reg > SQ_W'(v_reg));
            C_DIV_BUSY:    cond_true = (cnt_reg != '0);
            C_REM_ZERO:    cond_true = (rem_reg == '0);
            C_OUT_BLOCKED: cond_true = out_blocked;
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next      = cond_true ? uw.target : step_reg + step_t'(1);
        v_next         = v_reg;
        last_next      = last_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        prime_next     = prime_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_prime_next = out_prime_reg;
        out_all_next   = out_all_reg;
        out_done_next  = out_done_reg;

        case (uw.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                v_next    = value;
                last_next = last_element;
            end
            OP_INIT_D:
            begin
                d_next = DIV_W'(3);
            end
            OP_SQUARE:
            begin
                sq_next = SQ_W'(d_reg) * SQ_W'(d_reg);
            end
            OP_DIV_START:
            begin
                rem_next = '0;
                cnt_next = CNT_W'(DATA_WIDTH - 1);
            end
            OP_DIV_STEP:
            begin
                // restoring remainder: shift in the next bit, subtract when it fits
                rem_next = (rem_shift >= d_ext) ? rem_shift - d_ext : rem_shift;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_NEXT_D:
            begin
                d_next = d_reg + DIV_W'(2);
            end
            OP_SET_YES:
            begin
                prime_next = 1'b1;
            end
            OP_SET_NO:
            begin
                prime_next = 1'b0;
                step_next  = S_EMIT;
            end
            OP_EMIT:
            begin
                // hold until the output register frees up
                if (!out_blocked)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = prime_reg;
                    out_all_next   = all_now;
                    out_done_next  = last_reg;
                    run_next       = last_reg ? 1'b1 : all_now;
                    step_next      = S_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            run_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        last_reg      <= last_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        prime_reg     <= prime_next;
        out_prime_reg <= out_prime_next;
        out_all_reg   <= out_all_next;
        out_done_reg  <= out_done_next;
    end

    assign in_stall         = (step_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign element_is_prime = out_prime_reg;
    assign all_prime_so_far = out_all_reg;
    assign array_done       = out_done_reg;

endmodule
`default_nettype wire

// ----- tb/sv/all_prime_array_check_unit_test.sv -----
`timescale 1ns / 100ps

module all_prime_array_check_unit_test;
    import apac_pkg::*;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } element_t;

    typedef struct packed {
        logic prime;
        logic all_prime;
        logic done;
    } verdict_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic signed [DATA_WIDTH-1:0] value = '0;
    logic                         last_element = 1'b0;
    logic                         out_stall = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic                         element_is_prime;
    logic                         all_prime_so_far;
    logic                         array_done;

    element_t pending_elements[$];
    verdict_t expected_verdicts[$];
    bit       array_all_prime = 1'b1;
    bit       in_taken = 1'b0;
    int       mismatch_count = 0;
    int       send_idle_pct = 11;
    int       recv_idle_pct = 84;
    bit       hold_req = 1'b0;
    bit       hold_served = 1'b0;
    int       hold_cnt = 0;

    all_prime_array_check_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .value            (value),
        .last_element     (last_element),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .element_is_prime (element_is_prime),
        .all_prime_so_far (all_prime_so_far),
        .array_done       (array_done)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit prime_by_trial(input logic signed [DATA_WIDTH-1:0] v);
        longint unsigned n;
        longint unsigned d;
        if (v <= 1)
            return 1'b0;
        n = v;
        if (n == 2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        // square at full width, no overflow near the top of the range
        for (d = 3; d * d <= n; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_prime();
        logic signed [DATA_WIDTH-1:0] v;
        int top;
        top = ($urandom_range(9) == 0) ? 65535 : 4095;
        if ($urandom_range(15) == 0)
            return 2;
        do
            v = $urandom_range(top, 3) | 1;
        while (!prime_by_trial(v));
        return v;
    endfunction

    // keep one factor small so the divisor loop exits early
    function automatic logic signed [DATA_WIDTH-1:0] pick_composite();
        logic signed [DATA_WIDTH-1:0] v;
        v = ($urandom_range(31, 3) | 1) * pick_prime();
        return v;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_noise();
        logic signed [DATA_WIDTH-1:0] v;
        case ($urandom_range(5))
            0:
            begin
                v = $urandom;
                v[DATA_WIDTH-1] = 1'b1;
            end
            1: v = $urandom_range(1);
            2:
            begin
                v = $urandom;
                v[DATA_WIDTH-1] = 1'b0;
                v[0] = 1'b0;
            end
            3: v = $urandom_range(715827882, 1) * 3;
            4: v = pick_composite();
            default: v = pick_prime();
        endcase
        return v;
    endfunction

    task automatic add_element(input logic signed [DATA_WIDTH-1:0] v, input logic l);
        pending_elements.push_back('{value: v, last: l});
    endtask

    // all-prime arrays 45 times in 100, one bad element 30 times, pure noise 25 times
    task automatic queue_random_array(output int count);
        int len;
        int kind;
        int bad_at;
        logic signed [DATA_WIDTH-1:0] v;
        len = $urandom_range(5, 1);
        kind = $urandom_range(99);
        if (kind < 45)
            bad_at = -1;
        else if (kind < 75)
            bad_at = $urandom_range(len - 1);
        else
            bad_at = -2;
        for (int i = 0; i < len; i++)
        begin
            if (bad_at == -2)
                v = pick_noise();
            else if (i == bad_at)
                v = ($urandom_range(1) == 0) ? pick_composite() : pick_noise();
            else
                v = pick_prime();
            add_element(v, i == len - 1);
        end
        count = len;
    endtask

    task automatic queue_random(input int target);
        int made;
        int n;
        made = 0;
        while (made < target)
        begin
            queue_random_array(n);
            made += n;
        end
    endtask

    task automatic wait_drained();
        while (pending_elements.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // sender: hold the payload until the transaction is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_elements.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                value <= pending_elements[0].value;
                last_element <= pending_elements[0].last;
                void'(pending_elements.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cnt != 0)
        begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_req && !hold_served)
        begin
            out_stall <= 1'b1;
            hold_cnt <= 400;
            hold_served <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        verdict_t got;
        verdict_t want;
        bit prime;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                prime = prime_by_trial(value);
                want = '{prime, array_all_prime & prime, last_element};
                expected_verdicts.push_back(want);
                // start a fresh verdict after the last element
                array_all_prime = last_element ? 1'b1 : want.all_prime;
            end
            if (out_valid && !out_stall)
            begin
                got = '{element_is_prime, all_prime_so_far, array_done};
                if (expected_verdicts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: prime=%0b all=%0b done=%0b",
                                 got.prime, got.all_prime, got.done);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %0b/%0b/%0b got %0b/%0b/%0b",
                                     want.prime, want.all_prime, want.done,
                                     got.prime, got.all_prime, got.done);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // small primes, verdict true
        add_element(2, 1'b0);
        add_element(3, 1'b0);
        add_element(5, 1'b0);
        add_element(7, 1'b0);
        add_element(11, 1'b1);
        // odd square right at the divisor bound breaks the array
        add_element(13, 1'b0);
        add_element(9, 1'b0);
        add_element(17, 1'b1);
        // largest positive value, a prime
        add_element(32'sh7FFF_FFFF, 1'b1);
        // negative, zero, one, even
        add_element(32'sh8000_0000, 1'b0);
        add_element(-1, 1'b0);
        add_element(0, 1'b0);
        add_element(1, 1'b0);
        add_element(4, 1'b1);
        add_element(32'sh7FFF_FFFE, 1'b0);
        add_element(961, 1'b0);
        add_element(65521, 1'b1);
        add_element(25, 1'b0);
        add_element(32'sh7FFF_FFFD, 1'b1);
        add_element(65537, 1'b1);
        queue_random(30);
        wait_drained();

        send_idle_pct = 84;
        recv_idle_pct = 11;
        queue_random(30);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(35);
        hold_req = 1'b1;
        wait_drained();

        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/apac_pkg.sv
design/all_prime_array_check_unit.sv
tb/sv/all_prime_array_check_unit_test.sv
